>>> rtl/chkc_pkg.sv
// ----------------------------------------------------------------------------
// chkc_pkg
// Shared constants, status codes and the knee curve table for the chromaticity
// hull knee compressor.
// ----------------------------------------------------------------------------
package chkc_pkg;

  localparam int unsigned DIV_STEPS = 39;

  // knee start 0.815 in Q.30 and the span up to 1.0
  localparam logic [38:0] KNEE_K    = 39'd875099587;
  localparam logic [27:0] KNEE_S    = 28'd198642237;
  localparam logic [38:0] RATIO_SAT = 39'h3FFFFFFFFF;

  // configuration register indexes
  localparam logic CFG_CENTER_X = 1'b0;
  localparam logic CFG_CENTER_Y = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_CENTER = 2'd1,
    ST_FAIL   = 2'd2,
    ST_VERTEX = 2'd3
  } status_t;

  function automatic logic [16:0] knee_tab(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd4233;
      5'd2:    v = 17'd8668;
      5'd3:    v = 17'd13249;
      5'd4:    v = 17'd17929;
      5'd5:    v = 17'd22664;
      5'd6:    v = 17'd27413;
      5'd7:    v = 17'd32133;
      5'd8:    v = 17'd36781;
      5'd9:    v = 17'd41314;
      5'd10:   v = 17'd45688;
      5'd11:   v = 17'd49861;
      5'd12:   v = 17'd53786;
      5'd13:   v = 17'd57412;
      5'd14:   v = 17'd60679;
      5'd15:   v = 17'd63490;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/chkc_ram.sv
// ----------------------------------------------------------------------------
// chkc_ram
// Generic simple dual-port RAM, one write port, one read port with registered
// read data held while the read enable is low.
// ----------------------------------------------------------------------------
module chkc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/chromaticity_hull_knee_compress.sv
// ----------------------------------------------------------------------------
// chromaticity_hull_knee_compress
// Radial gamut compression toward a hull polygon held in RAM, with a
// power-1.2 knee past ratio 0.815.
// Vertex writes, unloaded hull and center points answer in the cycle after start.
// Other points walk every hull edge; the walk stalls on a forward edge hit while
// the 39-step serial divider is busy, and points past the knee are then compressed.
// One transaction in flight at a time; busy is high while a point is walked or compressed.
// Synchronous active-low reset clears control and hull-loaded flag and sets the default center.
// ----------------------------------------------------------------------------
module chromaticity_hull_knee_compress #(
  parameter int HULL_VERTICES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [5:0]  in_vertex_index,
  input  logic [15:0] in_vertex_x,
  input  logic [15:0] in_vertex_y,
  input  logic [15:0] in_point_x,
  input  logic [15:0] in_point_y,
  output logic        out_valid,
  output logic [15:0] out_x,
  output logic [15:0] out_y,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = (HULL_VERTICES > 1) ? $clog2(HULL_VERTICES) : 1;
  localparam int CW = $clog2(HULL_VERTICES + 1);

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_WALK = 15'h0002,
    S_PX   = 15'h0004,
    S_LX   = 15'h0008,
    S_WX   = 15'h0010,
    S_PY   = 15'h0020,
    S_LY   = 15'h0040,
    S_WY   = 15'h0080,
    S_LM   = 15'h0100,
    S_WM   = 15'h0200,
    S_K1   = 15'h0400,
    S_K2   = 15'h0800,
    S_K3   = 15'h1000,
    S_OM   = 15'h2000,
    S_FIN  = 15'h4000
  } state_t;

  state_t state_r;
  logic [15:0] cx_r, cy_r;
  logic loaded_r;
  logic out_valid_r, out_valid_nxt;
  logic [15:0] out_x_r, out_y_r;
  logic [1:0] out_status_r;

  logic signed [16:0] dx_r, dy_r;
  logic [15:0] px_r, py_r;

  // edge walk pipeline
  logic [CW-1:0] cnt_r;
  logic iss_done_r;
  logic p0_vld_r, p0_first_r, p0_wrap_r;
  logic [15:0] v0x_r, v0y_r, prvx_r, prvy_r;
  logic s1_vld_r;
  logic signed [16:0] ex_r, ey_r, ox_r, oy_r;
  logic s2_vld_r;
  logic signed [33:0] m1_r, m2_r, m3_r, m4_r, m5_r, m6_r;
  logic s3_vld_r, s3_hit_r;
  logic [33:0] s3_den_r, s3_tn_r;
  logic [33:0] wk_den_r, wk_tn_r;
  logic wk_sat_r;
  logic found_r;
  logic [38:0] best_r;
  logic [33:0] best_tn_r, best_den_r;

  // post-walk datapath
  logic [32:0] ph_r, pl_r;
  logic [17:0] bxm_r, bym_r;
  logic [23:0] m_r;
  logic [16:0] ti_r;
  logic [36:0] kp_r;
  logic [44:0] sg_r;
  logic [30:0] kn_r;
  logic [18:0] xm_r, ym_r;

  // serial divider
  logic dv_busy_r, dv_fin_r, dv_go;
  logic [39:0] dv_rem_r, dv_dvs_r, dv_rem_in, dv_dvs_in;
  logic [38:0] dv_low_r, dv_low_in, dv_q_r;
  logic [5:0] dv_cnt_r;
  logic [40:0] dv_sh;
  logic dv_ge;
  logic [39:0] dv_rem_nxt;

  logic accept, at_center, slot_ok, slot_last, adv, cnt_end, walk_end, ram_we, ram_re;
  logic signed [16:0] acc_dx, acc_dy;
  logic [31:0] ram_rdata;
  logic [15:0] cur_x, cur_y;
  logic signed [34:0] den_w, tn_w, un_w, dn_w, tp_w, up_w;
  logic hit_w, better_w;
  logic [38:0] r_new;
  logic [16:0] ndx_w, ndy_w;
  logic [15:0] mag_w;
  logic [50:0] lnum_w;
  logic [38:0] num2_w;
  logic [16:0] tab_lo, tab_hi, g_w;
  logic [49:0] xprod_w, yprod_w;
  logic signed [20:0] xs_w, ys_w, fx_w, fy_w;
  logic [15:0] fxc_w, fyc_w;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign at_center = (in_point_x == cx_r) && (in_point_y == cy_r);
  assign slot_ok   = ({3'b000, in_vertex_index} < 9'(HULL_VERTICES));
  assign slot_last = ({3'b000, in_vertex_index} == 9'(HULL_VERTICES - 1));
  assign acc_dx    = {1'b0, in_point_x} - {1'b0, cx_r};
  assign acc_dy    = {1'b0, in_point_y} - {1'b0, cy_r};

  assign ram_we  = accept && !in_mode && slot_ok;
  assign adv     = !(s3_vld_r && s3_hit_r && dv_busy_r);
  assign cnt_end = (cnt_r == CW'(HULL_VERTICES));
  assign ram_re  = (state_r == S_WALK) && adv && !iss_done_r && !cnt_end;
  assign walk_end = iss_done_r && !p0_vld_r && !s1_vld_r && !s2_vld_r && !s3_vld_r &&
                    !dv_busy_r && !dv_fin_r;

  assign out_valid_nxt = (accept && (!in_mode || !loaded_r || at_center)) ||
                         ((state_r == S_WALK) && walk_end &&
                          (!found_r || (best_r <= chkc_pkg::KNEE_K))) ||
                         (state_r == S_FIN);

  chkc_ram #(
    .WIDTH (32),
    .DEPTH (HULL_VERTICES)
  ) u_hull_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_vertex_index)),
    .wdata ({in_vertex_x, in_vertex_y}),
    .re    (ram_re),
    .raddr (AW'(cnt_r)),
    .rdata (ram_rdata)
  );

  always_comb begin
    cur_x = p0_wrap_r ? v0x_r : ram_rdata[31:16];
    cur_y = p0_wrap_r ? v0y_r : ram_rdata[15:0];
    den_w = 35'(m1_r) - 35'(m2_r);
    tn_w  = 35'(m3_r) - 35'(m4_r);
    un_w  = 35'(m5_r) - 35'(m6_r);
    dn_w  = den_w[34] ? -den_w : den_w;
    tp_w  = den_w[34] ? -tn_w  : tn_w;
    up_w  = den_w[34] ? -un_w  : un_w;
    hit_w = (den_w != 35'sd0) && (tp_w > 35'sd0) && (up_w >= 35'sd0) && (up_w <= dn_w);
    r_new = (wk_sat_r || (dv_q_r > chkc_pkg::RATIO_SAT)) ? chkc_pkg::RATIO_SAT : dv_q_r;
    better_w = !found_r || (r_new > best_r);
    ndx_w = -dx_r;
    ndy_w = -dy_r;
    mag_w = (state_r == S_PX) ? (dx_r[16] ? ndx_w[15:0] : dx_r[15:0])
                              : (dy_r[16] ? ndy_w[15:0] : dy_r[15:0]);
    lnum_w = 51'({ph_r, 17'b0}) + 51'(pl_r) + 51'(best_den_r >> 1);
    num2_w = best_r - chkc_pkg::KNEE_K;
    tab_lo = chkc_pkg::knee_tab({1'b0, m_r[23:20]});
    tab_hi = chkc_pkg::knee_tab({1'b0, m_r[23:20]} + 5'd1);
    g_w    = ti_r + kp_r[36:20];
    xprod_w = 50'(bxm_r) * 50'(kn_r) + 50'(32'h2000_0000);
    yprod_w = 50'(bym_r) * 50'(kn_r) + 50'(32'h2000_0000);
    xs_w = dx_r[16] ? -signed'({2'b00, xm_r}) : signed'({2'b00, xm_r});
    ys_w = dy_r[16] ? -signed'({2'b00, ym_r}) : signed'({2'b00, ym_r});
    fx_w = signed'({5'b00000, cx_r}) + xs_w;
    fy_w = signed'({5'b00000, cy_r}) + ys_w;
    fxc_w = fx_w[20] ? 16'd0 : ((fx_w > 21'sd65535) ? 16'hFFFF : fx_w[15:0]);
    fyc_w = fy_w[20] ? 16'd0 : ((fy_w > 21'sd65535) ? 16'hFFFF : fy_w[15:0]);
  end

  // divider operand select
  always_comb begin
    dv_go     = 1'b0;
    dv_rem_in = 40'(s3_den_r >> 9);
    dv_low_in = {s3_den_r[8:0], 30'b0};
    dv_dvs_in = 40'(s3_tn_r);
    case (state_r)
      S_WALK: begin
        dv_go = s3_vld_r && s3_hit_r && !dv_busy_r;
      end
      S_LX, S_LY: begin
        dv_go     = 1'b1;
        dv_rem_in = 40'(lnum_w >> 39);
        dv_low_in = lnum_w[38:0];
        dv_dvs_in = 40'(best_den_r);
      end
      S_LM: begin
        dv_go     = 1'b1;
        dv_rem_in = 40'(num2_w >> 15);
        dv_low_in = {num2_w[14:0], 24'b0};
        dv_dvs_in = 40'(num2_w) + 40'(chkc_pkg::KNEE_S);
      end
      default: begin
        dv_go = 1'b0;
      end
    endcase
  end

  assign dv_sh      = {dv_rem_r, dv_low_r[38]};
  assign dv_ge      = (dv_sh >= {1'b0, dv_dvs_r});
  assign dv_rem_nxt = dv_ge ? 40'(dv_sh - {1'b0, dv_dvs_r}) : dv_sh[39:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
      dv_fin_r  <= 1'b0;
    end else begin
      dv_fin_r <= !dv_go && dv_busy_r && (dv_cnt_r == 6'(chkc_pkg::DIV_STEPS - 1));
      if (dv_go) begin
        dv_busy_r <= 1'b1;
      end else if (dv_busy_r && (dv_cnt_r == 6'(chkc_pkg::DIV_STEPS - 1))) begin
        dv_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dv_go) begin
      dv_rem_r <= dv_rem_in;
      dv_low_r <= dv_low_in;
      dv_dvs_r <= dv_dvs_in;
      dv_q_r   <= '0;
      dv_cnt_r <= '0;
    end else if (dv_busy_r) begin
      dv_rem_r <= dv_rem_nxt;
      dv_low_r <= {dv_low_r[37:0], 1'b0};
      dv_q_r   <= {dv_q_r[37:0], dv_ge};
      dv_cnt_r <= dv_cnt_r + 6'd1;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= 16'd20493;
      cy_r <= 16'd21561;
    end else if (cfg_we) begin
      if (cfg_index == chkc_pkg::CFG_CENTER_X) begin
        cx_r <= cfg_wdata;
      end else begin
        cy_r <= cfg_wdata;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      iss_done_r  <= 1'b1;
      p0_vld_r    <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (!in_mode) begin
              if (slot_ok && slot_last) begin
                loaded_r <= 1'b1;
              end
            end else if (loaded_r && !at_center) begin
              state_r    <= S_WALK;
              cnt_r      <= '0;
              iss_done_r <= 1'b0;
              p0_vld_r   <= 1'b0;
              s1_vld_r   <= 1'b0;
              s2_vld_r   <= 1'b0;
              s3_vld_r   <= 1'b0;
              found_r    <= 1'b0;
            end
          end
        end
        S_WALK: begin
          if (adv) begin
            p0_vld_r <= !iss_done_r;
            s1_vld_r <= p0_vld_r && !p0_first_r;
            s2_vld_r <= s1_vld_r;
            s3_vld_r <= s2_vld_r;
            if (!iss_done_r) begin
              if (cnt_end) begin
                iss_done_r <= 1'b1;
              end else begin
                cnt_r <= cnt_r + CW'(1);
              end
            end
          end
          if (dv_fin_r && better_w) begin
            found_r <= 1'b1;
          end
          if (walk_end) begin
            if (!found_r || (best_r <= chkc_pkg::KNEE_K)) begin
              state_r <= S_IDLE;
            end else begin
              state_r <= S_PX;
            end
          end
        end
        S_PX: state_r <= S_LX;
        S_LX: state_r <= S_WX;
        S_WX: begin
          if (dv_fin_r) begin
            state_r <= S_PY;
          end
        end
        S_PY: state_r <= S_LY;
        S_LY: state_r <= S_WY;
        S_WY: begin
          if (dv_fin_r) begin
            state_r <= S_LM;
          end
        end
        S_LM: state_r <= S_WM;
        S_WM: begin
          if (dv_fin_r) begin
            state_r <= S_K1;
          end
        end
        S_K1: state_r <= S_K2;
        S_K2: state_r <= S_K3;
        S_K3: state_r <= S_OM;
        S_OM: state_r <= S_FIN;
        S_FIN: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      dx_r <= acc_dx;
      dy_r <= acc_dy;
      px_r <= in_point_x;
      py_r <= in_point_y;
      if (!in_mode) begin
        out_x_r      <= '0;
        out_y_r      <= '0;
        out_status_r <= chkc_pkg::ST_VERTEX;
      end else if (!loaded_r) begin
        out_x_r      <= '0;
        out_y_r      <= '0;
        out_status_r <= chkc_pkg::ST_FAIL;
      end else begin
        out_x_r      <= in_point_x;
        out_y_r      <= in_point_y;
        out_status_r <= chkc_pkg::ST_CENTER;
      end
    end

    if ((state_r == S_WALK) && adv) begin
      p0_first_r <= (cnt_r == '0);
      p0_wrap_r  <= cnt_end;
      if (p0_vld_r) begin
        prvx_r <= cur_x;
        prvy_r <= cur_y;
        if (p0_first_r) begin
          v0x_r <= cur_x;
          v0y_r <= cur_y;
        end
      end
      ex_r <= {1'b0, cur_x} - {1'b0, prvx_r};
      ey_r <= {1'b0, cur_y} - {1'b0, prvy_r};
      ox_r <= {1'b0, cx_r} - {1'b0, prvx_r};
      oy_r <= {1'b0, cy_r} - {1'b0, prvy_r};
      m1_r <= 34'(dx_r) * 34'(ey_r);
      m2_r <= 34'(dy_r) * 34'(ex_r);
      m3_r <= 34'(oy_r) * 34'(ex_r);
      m4_r <= 34'(ox_r) * 34'(ey_r);
      m5_r <= 34'(oy_r) * 34'(dx_r);
      m6_r <= 34'(ox_r) * 34'(dy_r);
      s3_hit_r <= hit_w;
      s3_den_r <= dn_w[33:0];
      s3_tn_r  <= tp_w[33:0];
    end

    if ((state_r == S_WALK) && dv_go) begin
      wk_den_r <= s3_den_r;
      wk_tn_r  <= s3_tn_r;
      wk_sat_r <= ({9'b0, s3_den_r} >= {s3_tn_r, 9'b0});
    end

    if ((state_r == S_WALK) && dv_fin_r && better_w) begin
      best_r     <= r_new;
      best_tn_r  <= wk_tn_r;
      best_den_r <= wk_den_r;
    end

    if ((state_r == S_WALK) && walk_end) begin
      if (!found_r) begin
        out_x_r      <= '0;
        out_y_r      <= '0;
        out_status_r <= chkc_pkg::ST_FAIL;
      end else begin
        out_x_r      <= px_r;
        out_y_r      <= py_r;
        out_status_r <= chkc_pkg::ST_DONE;
      end
    end

    if ((state_r == S_PX) || (state_r == S_PY)) begin
      ph_r <= 33'(mag_w) * 33'(best_tn_r[33:17]);
      pl_r <= 33'(mag_w) * 33'(best_tn_r[16:0]);
    end
    if ((state_r == S_WX) && dv_fin_r) begin
      bxm_r <= dv_q_r[17:0];
    end
    if ((state_r == S_WY) && dv_fin_r) begin
      bym_r <= dv_q_r[17:0];
    end
    if ((state_r == S_WM) && dv_fin_r) begin
      m_r <= dv_q_r[23:0];
    end
    if (state_r == S_K1) begin
      ti_r <= tab_lo;
      kp_r <= 37'(tab_hi - tab_lo) * 37'(m_r[19:0]);
    end
    if (state_r == S_K2) begin
      sg_r <= 45'(chkc_pkg::KNEE_S) * 45'(g_w);
    end
    if (state_r == S_K3) begin
      kn_r <= 31'(chkc_pkg::KNEE_K) + 31'(sg_r[44:16]);
    end
    if (state_r == S_OM) begin
      xm_r <= xprod_w[48:30];
      ym_r <= yprod_w[48:30];
    end
    if (state_r == S_FIN) begin
      out_x_r      <= fxc_w;
      out_y_r      <= fyc_w;
      out_status_r <= chkc_pkg::ST_DONE;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_status = out_status_r;

endmodule

>>> rtl/chkc_checker.sv
// ----------------------------------------------------------------------------
// chkc_checker
// Port-level checks for the chromaticity hull knee compressor, bound to the
// top level.
// ----------------------------------------------------------------------------
module chkc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_mode,
  input logic        out_valid,
  input logic [15:0] out_x,
  input logic [15:0] out_y,
  input logic [1:0]  out_status
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("outputs active after reset");

  a_vertex_ack: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_mode |=> out_valid && (out_status == chkc_pkg::ST_VERTEX) && !busy)
    else $error("vertex transaction not acknowledged");

  a_point_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode |=> out_valid || busy)
    else $error("point transaction dropped");

  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == chkc_pkg::ST_VERTEX) || (out_status == chkc_pkg::ST_FAIL))
      |-> (out_x == 16'd0) && (out_y == 16'd0))
    else $error("nonzero payload on vertex or failure result");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && busy |-> 1'b0)
    else $error("result while still busy");

endmodule

bind chromaticity_hull_knee_compress chkc_checker u_chkc_checker (.*);
